### sv/sfpc_pkg.sv
package sfpc_pkg;

  localparam int unsigned TABLE_ENTRIES = 256;
  localparam int unsigned AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned CW = $clog2(TABLE_ENTRIES + 1);

  localparam logic [15:0] MIN_LENGTH     = 16'd58;
  localparam logic [15:0] ETYPE_IPV6     = 16'h86DD;
  localparam logic [7:0]  NH_ROUTING_HDR = 8'd43;
  localparam logic [7:0]  RT_TYPE_SEG    = 8'd4;

  typedef struct packed {
    logic [47:0] smac;
    logic [47:0] dmac;
    logic [63:0] shi;
    logic [63:0] slo;
    logic [63:0] dhi;
    logic [63:0] dlo;
  } flow_key_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_READ,
    ST_COMPARE,
    ST_INCR
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic rd;
    logic idx_clr;
    logic idx_inc;
    logic emit_zero;
    logic emit_full;
    logic emit_hit;
    logic emit_new;
  } ctl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic qual;
    logic empty;
    logic full;
    logic last;
    logic hit;
  } ctl_sts_t;

endpackage

### sv/sfpc_ctrl.sv
module sfpc_ctrl import sfpc_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  ctl_sts_t sts,
  output ctl_cmd_t cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    busy      = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        cmd.idx_clr = 1'b1;
        if (!sts.qual) begin
          cmd.emit_zero = 1'b1;
          state_nxt     = ST_IDLE;
        end else if (sts.empty) begin
          cmd.emit_new = 1'b1;
          state_nxt    = ST_IDLE;
        end else begin
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        cmd.rd    = 1'b1;
        state_nxt = ST_COMPARE;
      end
      ST_COMPARE: begin
        if (sts.hit) begin
          state_nxt = ST_INCR;
        end else if (sts.last) begin
          // no match among filled slots
          if (sts.full) begin
            cmd.emit_full = 1'b1;
          end else begin
            cmd.emit_new = 1'b1;
          end
          state_nxt = ST_IDLE;
        end else begin
          cmd.idx_inc = 1'b1;
          state_nxt   = ST_READ;
        end
      end
      ST_INCR: begin
        cmd.emit_hit = 1'b1;
        state_nxt    = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

### sv/sfpc_datapath.sv
module sfpc_datapath import sfpc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  ctl_cmd_t    cmd,
  output ctl_sts_t    sts,
  input  logic [15:0] in_packet_length,
  input  logic [15:0] in_ether_type,
  input  logic [7:0]  in_next_header,
  input  logic [7:0]  in_routing_type,
  input  flow_key_t   in_key,
  output logic        out_valid,
  output logic        out_counted,
  output logic        out_new_flow,
  output logic        out_table_full,
  output logic [7:0]  out_entry_index,
  output logic [63:0] out_flow_count
);

  flow_key_t   key_mem [TABLE_ENTRIES];
  logic [63:0] cnt_mem [TABLE_ENTRIES];

  flow_key_t   key_r, key_rd_r;
  logic [63:0] cnt_rd_r;
  logic        qual_r;
  logic [AW-1:0] idx_r;
  logic [CW-1:0] fill_r;

  logic        out_valid_r, out_counted_r, out_new_flow_r, out_table_full_r;
  logic [7:0]  out_entry_index_r;
  logic [63:0] out_flow_count_r;

  logic          qual_in;
  logic          wr_cnt, wr_key;
  logic [AW-1:0] wr_addr;
  logic [63:0]   wr_cnt_val;
  logic [AW+7:0] idx_ext, fill_ext;

  assign qual_in = (in_packet_length >= MIN_LENGTH) && (in_ether_type == ETYPE_IPV6) &&
                   (in_next_header == NH_ROUTING_HDR) &&
                   (in_routing_type == RT_TYPE_SEG);

  assign sts.qual  = qual_r;
  assign sts.empty = (fill_r == '0);
  assign sts.full  = (fill_r == CW'(TABLE_ENTRIES));
  assign sts.last  = (({1'b0, idx_r} + CW'(1)) == fill_r);
  assign sts.hit   = (key_rd_r == key_r);

  assign wr_key     = cmd.emit_new;
  assign wr_cnt     = cmd.emit_new | cmd.emit_hit;
  assign wr_addr    = cmd.emit_new ? fill_r[AW-1:0] : idx_r;
  assign wr_cnt_val = cmd.emit_new ? 64'd1 : cnt_rd_r + 64'd1;
  assign idx_ext    = {8'd0, idx_r};
  assign fill_ext   = {8'd0, fill_r[AW-1:0]};

  // flow table
  always_ff @(posedge clk) begin
    if (wr_key) begin
      key_mem[wr_addr] <= key_r;
    end
    if (wr_cnt) begin
      cnt_mem[wr_addr] <= wr_cnt_val;
    end
    if (cmd.rd) begin
      key_rd_r <= key_mem[idx_r];
      cnt_rd_r <= cnt_mem[idx_r];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      key_r  <= in_key;
      qual_r <= qual_in;
    end
    if (cmd.idx_clr) begin
      idx_r <= '0;
    end else if (cmd.idx_inc) begin
      idx_r <= idx_r + AW'(1);
    end
    out_counted_r     <= cmd.emit_hit | cmd.emit_new;
    out_new_flow_r    <= cmd.emit_new;
    out_table_full_r  <= cmd.emit_full;
    out_entry_index_r <= cmd.emit_hit ? idx_ext[7:0] : (cmd.emit_new ? fill_ext[7:0] : 8'd0);
    out_flow_count_r  <= wr_cnt ? wr_cnt_val : 64'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.emit_new) begin
        fill_r <= fill_r + CW'(1);
      end
      out_valid_r <= cmd.emit_zero | cmd.emit_full | cmd.emit_hit | cmd.emit_new;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_counted     = out_counted_r;
  assign out_new_flow    = out_new_flow_r;
  assign out_table_full  = out_table_full_r;
  assign out_entry_index = out_entry_index_r;
  assign out_flow_count  = out_flow_count_r;

endmodule

### sv/srv6_flow_packet_counter.sv
// channel   signals                                          accepted when
// -------   ----------------------------------------------   ---------------------------
// input     start, busy, in_* header fields                  start && !busy at clk edge
// result    out_valid strobe, out_* result fields            every cycle out_valid is high
//
// an item that does not qualify, or finds the table empty, ends in the check state; otherwise
// the filled slots are scanned in order through the single read port of the flow table,
// each slot with a read state and a compare state, until a hit or the last filled slot,
// and a hit goes through one more state for the count update
// out_valid rises in the same cycle as busy falls
// synchronous reset clears the fill count, so the table starts empty at once
// the receiver cannot stall, so results are never held back
module srv6_flow_packet_counter import sfpc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [15:0] in_packet_length,
  input  logic [15:0] in_ether_type,
  input  logic [7:0]  in_next_header,
  input  logic [7:0]  in_routing_type,
  input  logic [47:0] in_source_mac,
  input  logic [47:0] in_dest_mac,
  input  logic [63:0] in_src_ip_high,
  input  logic [63:0] in_src_ip_low,
  input  logic [63:0] in_dst_ip_high,
  input  logic [63:0] in_dst_ip_low,
  output logic        out_valid,
  output logic        out_counted,
  output logic        out_new_flow,
  output logic        out_table_full,
  output logic [7:0]  out_entry_index,
  output logic [63:0] out_flow_count
);

  ctl_cmd_t  cmd;
  ctl_sts_t  sts;
  flow_key_t in_key;

  // flow key as stored in the table
  assign in_key.smac = in_source_mac;
  assign in_key.dmac = in_dest_mac;
  assign in_key.shi  = in_src_ip_high;
  assign in_key.slo  = in_src_ip_low;
  assign in_key.dhi  = in_dst_ip_high;
  assign in_key.dlo  = in_dst_ip_low;

  // sequencer: qualify, linear scan of filled slots, then update, insert or report a full table
  sfpc_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  // key and count stores, fill count, result registers
  sfpc_datapath u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_packet_length (in_packet_length),
    .in_ether_type    (in_ether_type),
    .in_next_header   (in_next_header),
    .in_routing_type  (in_routing_type),
    .in_key           (in_key),
    .out_valid        (out_valid),
    .out_counted      (out_counted),
    .out_new_flow     (out_new_flow),
    .out_table_full   (out_table_full),
    .out_entry_index  (out_entry_index),
    .out_flow_count   (out_flow_count)
  );

endmodule

### sv/sfpc_checker.sv
module sfpc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic        out_valid,
  input logic        out_counted,
  input logic        out_new_flow,
  input logic        out_table_full,
  input logic [7:0]  out_entry_index,
  input logic [63:0] out_flow_count
);

  // an accepted item keeps the block busy for the next cycle
  a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy) else $error("busy not raised after accept");

  // result strobes never come in back-to-back cycles
  a_strobe_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("back to back result strobes");

  // a new flow is always counted, with count one
  a_new_counted: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_new_flow |-> out_counted && out_flow_count == 64'd1)
    else $error("new flow not counted as one");

  // a full table result carries nothing else
  a_full_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_table_full |-> !out_counted && !out_new_flow &&
    out_entry_index == 8'd0 && out_flow_count == 64'd0)
    else $error("table full result not clean");

endmodule

bind srv6_flow_packet_counter sfpc_checker u_sfpc_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .start           (start),
  .busy            (busy),
  .out_valid       (out_valid),
  .out_counted     (out_counted),
  .out_new_flow    (out_new_flow),
  .out_table_full  (out_table_full),
  .out_entry_index (out_entry_index),
  .out_flow_count  (out_flow_count)
);
